// ===== sv/ffha_pkg.sv =====
// Shared types, constants and codes of the first-fit heap allocator.
// Used by ffha_ctrl and the top module; depends on nothing.
`timescale 1ns / 1ps
package ffha_pkg;

	localparam int ARENA_BYTES  = 4096;
	localparam int HEADER_BYTES = 8;
	localparam int ARENA_MIN    = 64;
	localparam int ADDR_W       = 12;
	localparam int SIZE_W       = 13;
	localparam int BLK_W        = 10;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_REPORT = 2'd2;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic              start;
		logic              free;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	typedef struct packed {
		logic [1:0]        op;
		logic [SIZE_W-1:0] req;
		logic [ADDR_W-1:0] rel;
	} item_t;

	typedef struct packed {
		logic [SIZE_W-1:0] lf;
		logic [SIZE_W-1:0] ub;
		logic [BLK_W-1:0]  nb;
		logic [ADDR_W-1:0] granted;
		logic              ok;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		hdr_t              wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} main_req_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [ADDR_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} back_req_t;

	typedef enum logic [4:0] {
		ST_CLR, ST_INIT, ST_IDLE,
		ST_A_RD, ST_A_CHK, ST_A_W2,
		ST_F_RD, ST_F_B, ST_F_P, ST_F_N, ST_F_NX, ST_F_W1, ST_F_W2, ST_F_W3,
		ST_R_RD, ST_R_CHK, ST_DONE
	} state_t;

endpackage

// ===== sv/ffha_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/ffha_ctrl.sv =====
// Request sequencer: walks the block chain in header memory, splits, merges and reports.
// Depends on ffha_pkg; drives the header and back-link memories.
`timescale 1ns / 1ps
module ffha_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [12:0]               cfg_wdata,
	input  logic                      start,
	input  ffha_pkg::item_t           item,
	output logic                      idle,
	output logic                      res_valid,
	input  logic                      res_ready,
	output ffha_pkg::result_t         res,
	output ffha_pkg::main_req_t       main_req,
	input  ffha_pkg::hdr_t            main_rdata,
	output ffha_pkg::back_req_t       back_req,
	input  logic [ffha_pkg::ADDR_W-1:0] back_rdata
);

	localparam logic [ffha_pkg::SIZE_W-1:0] HDR = ffha_pkg::SIZE_W'(ffha_pkg::HEADER_BYTES);
	localparam logic [ffha_pkg::SIZE_W-1:0] AMAX = ffha_pkg::SIZE_W'(ffha_pkg::ARENA_BYTES);
	localparam logic [ffha_pkg::SIZE_W-1:0] AMIN = ffha_pkg::SIZE_W'(ffha_pkg::ARENA_MIN);
	localparam logic [ffha_pkg::ADDR_W-1:0] CLR_LAST = ffha_pkg::ADDR_W'(ffha_pkg::ARENA_BYTES - 1);

	ffha_pkg::state_t state_q, state_d;
	logic [ffha_pkg::SIZE_W-1:0] arena_q;
	logic [ffha_pkg::ADDR_W-1:0] clr_q;
	ffha_pkg::item_t   item_q;
	ffha_pkg::result_t res_q;
	logic [ffha_pkg::SIZE_W-1:0] off_q, nxt_q, after_q;
	logic [ffha_pkg::BLK_W-1:0]  nb_q;
	logic [ffha_pkg::SIZE_W-1:0] ub_q, lf_q;
	logic [ffha_pkg::ADDR_W-1:0] b_q, p_q;
	logic [ffha_pkg::SIZE_W-1:0] sb_q, sp_q, nx_q, snx_q;
	logic pf_q, nf_q;

	logic [ffha_pkg::SIZE_W-1:0] cfg_sat, pay, rem, nxt, after, off_walk, merged, nn;
	logic [ffha_pkg::ADDR_W-1:0] b;
	logic fit, split, off_in, bad_rel;

	always_comb begin
		cfg_sat  = (cfg_wdata > AMAX) ? AMAX : ((cfg_wdata < AMIN) ? AMIN : cfg_wdata);
		pay      = main_rdata.size - HDR;
		fit      = main_rdata.free && (pay >= item_q.req);
		rem      = pay - item_q.req;
		split    = rem >= HDR;
		nxt      = off_q + HDR + item_q.req;
		after    = nxt + rem;
		off_walk = off_q + main_rdata.size;
		off_in   = off_q < arena_q;
		b        = item_q.rel - ffha_pkg::ADDR_W'(ffha_pkg::HEADER_BYTES);
		bad_rel  = ({1'b0, item_q.rel} < HDR) || ({1'b0, b} >= arena_q);
		merged   = sb_q + (pf_q ? sp_q : '0) + (nf_q ? snx_q : '0);
		nn       = nx_q + snx_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ffha_pkg::ST_CLR:   if (clr_q == CLR_LAST) state_d = ffha_pkg::ST_INIT;
			ffha_pkg::ST_INIT:  state_d = ffha_pkg::ST_IDLE;
			ffha_pkg::ST_IDLE: begin
				if (start) begin
					case (item.op)
						ffha_pkg::OP_ALLOC:  state_d = ffha_pkg::ST_A_RD;
						ffha_pkg::OP_FREE:   state_d = ffha_pkg::ST_F_RD;
						ffha_pkg::OP_REPORT: state_d = ffha_pkg::ST_R_RD;
						default:             state_d = ffha_pkg::ST_DONE;
					endcase
				end
			end
			ffha_pkg::ST_A_RD:  state_d = off_in ? ffha_pkg::ST_A_CHK : ffha_pkg::ST_DONE;
			ffha_pkg::ST_A_CHK: begin
				if (fit) state_d = split ? ffha_pkg::ST_A_W2 : ffha_pkg::ST_DONE;
				else state_d = ffha_pkg::ST_A_RD;
			end
			ffha_pkg::ST_A_W2:  state_d = ffha_pkg::ST_DONE;
			ffha_pkg::ST_F_RD:  state_d = bad_rel ? ffha_pkg::ST_DONE : ffha_pkg::ST_F_B;
			ffha_pkg::ST_F_B: begin
				if (!main_rdata.start || main_rdata.free) state_d = ffha_pkg::ST_DONE;
				else state_d = (b_q != '0) ? ffha_pkg::ST_F_P : ffha_pkg::ST_F_N;
			end
			ffha_pkg::ST_F_P:   state_d = ffha_pkg::ST_F_N;
			ffha_pkg::ST_F_N:   state_d = (nx_q < arena_q) ? ffha_pkg::ST_F_NX : ffha_pkg::ST_F_W1;
			ffha_pkg::ST_F_NX:  state_d = ffha_pkg::ST_F_W1;
			ffha_pkg::ST_F_W1:  state_d = ffha_pkg::ST_F_W2;
			ffha_pkg::ST_F_W2:  state_d = ffha_pkg::ST_F_W3;
			ffha_pkg::ST_F_W3:  state_d = ffha_pkg::ST_DONE;
			ffha_pkg::ST_R_RD:  state_d = off_in ? ffha_pkg::ST_R_CHK : ffha_pkg::ST_DONE;
			ffha_pkg::ST_R_CHK: state_d = ffha_pkg::ST_R_RD;
			ffha_pkg::ST_DONE:  if (res_ready) state_d = ffha_pkg::ST_IDLE;
			default:            state_d = ffha_pkg::ST_CLR;
		endcase
		if (cfg_we) state_d = ffha_pkg::ST_CLR;
	end

	always_comb begin
		main_req  = '0;
		back_req  = '0;
		idle      = state_q == ffha_pkg::ST_IDLE;
		res_valid = state_q == ffha_pkg::ST_DONE;
		res       = res_q;
		case (state_q)
			ffha_pkg::ST_CLR: begin
				main_req.we    = 1'b1;
				main_req.waddr = clr_q;
			end
			ffha_pkg::ST_INIT: begin
				main_req.we    = 1'b1;
				main_req.wdata = '{size: arena_q, start: 1'b1, free: 1'b1};
			end
			ffha_pkg::ST_A_RD, ffha_pkg::ST_R_RD: begin
				main_req.re    = off_in;
				main_req.raddr = off_q[ffha_pkg::ADDR_W-1:0];
			end
			ffha_pkg::ST_A_CHK: begin
				if (fit && split) begin
					main_req.we    = 1'b1;
					main_req.waddr = nxt[ffha_pkg::ADDR_W-1:0];
					main_req.wdata = '{size: rem, start: 1'b1, free: 1'b1};
					back_req.we    = 1'b1;
					back_req.waddr = nxt[ffha_pkg::ADDR_W-1:0];
					back_req.wdata = off_q[ffha_pkg::ADDR_W-1:0];
				end else if (fit) begin
					main_req.we    = 1'b1;
					main_req.waddr = off_q[ffha_pkg::ADDR_W-1:0];
					main_req.wdata = '{size: main_rdata.size, start: 1'b1, free: 1'b0};
				end
			end
			ffha_pkg::ST_A_W2: begin
				main_req.we    = 1'b1;
				main_req.waddr = off_q[ffha_pkg::ADDR_W-1:0];
				main_req.wdata = '{size: HDR + item_q.req, start: 1'b1, free: 1'b0};
				back_req.we    = after_q < arena_q;
				back_req.waddr = after_q[ffha_pkg::ADDR_W-1:0];
				back_req.wdata = nxt_q[ffha_pkg::ADDR_W-1:0];
			end
			ffha_pkg::ST_F_RD: begin
				main_req.re    = !bad_rel;
				main_req.raddr = b;
				back_req.re    = !bad_rel;
				back_req.raddr = b;
			end
			ffha_pkg::ST_F_B: begin
				main_req.re    = 1'b1;
				main_req.raddr = back_rdata;
			end
			ffha_pkg::ST_F_N: begin
				main_req.re    = nx_q < arena_q;
				main_req.raddr = nx_q[ffha_pkg::ADDR_W-1:0];
			end
			ffha_pkg::ST_F_W1: begin
				main_req.we    = 1'b1;
				main_req.waddr = pf_q ? p_q : b_q;
				main_req.wdata = '{size: merged, start: 1'b1, free: 1'b1};
				if (nf_q) begin
					back_req.we    = nn < arena_q;
					back_req.waddr = nn[ffha_pkg::ADDR_W-1:0];
					back_req.wdata = pf_q ? p_q : b_q;
				end else begin
					back_req.we    = pf_q && (nx_q < arena_q);
					back_req.waddr = nx_q[ffha_pkg::ADDR_W-1:0];
					back_req.wdata = p_q;
				end
			end
			ffha_pkg::ST_F_W2: begin
				main_req.we    = pf_q;
				main_req.waddr = b_q;
			end
			ffha_pkg::ST_F_W3: begin
				main_req.we    = nf_q;
				main_req.waddr = nx_q[ffha_pkg::ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::ST_CLR;
			arena_q <= AMAX;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				arena_q <= cfg_sat;
				clr_q   <= '0;
			end else if (state_q == ffha_pkg::ST_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ffha_pkg::ST_IDLE: begin
				item_q <= item;
				res_q  <= '0;
				off_q  <= '0;
				nb_q   <= '0;
				ub_q   <= '0;
				lf_q   <= '0;
			end
			ffha_pkg::ST_A_CHK: begin
				if (fit) begin
					res_q.ok      <= 1'b1;
					res_q.granted <= off_q[ffha_pkg::ADDR_W-1:0] +
					                 ffha_pkg::ADDR_W'(ffha_pkg::HEADER_BYTES);
					nxt_q         <= nxt;
					after_q       <= after;
				end else begin
					off_q <= off_walk;
				end
			end
			ffha_pkg::ST_F_RD: b_q <= b;
			ffha_pkg::ST_F_B: begin
				p_q  <= back_rdata;
				sb_q <= main_rdata.size;
				nx_q <= {1'b0, b_q} + main_rdata.size;
				pf_q <= 1'b0;
			end
			ffha_pkg::ST_F_P: begin
				pf_q <= ({1'b0, p_q} < arena_q) && main_rdata.start && main_rdata.free;
				sp_q <= main_rdata.size;
			end
			ffha_pkg::ST_F_N:  nf_q <= 1'b0;
			ffha_pkg::ST_F_NX: begin
				nf_q  <= main_rdata.free;
				snx_q <= main_rdata.size;
			end
			ffha_pkg::ST_F_W1: res_q.ok <= 1'b1;
			ffha_pkg::ST_R_RD: begin
				if (!off_in) begin
					res_q.ok <= 1'b1;
					res_q.nb <= nb_q;
					res_q.ub <= ub_q;
					res_q.lf <= lf_q;
				end
			end
			ffha_pkg::ST_R_CHK: begin
				if (main_rdata.free) begin
					if (pay > lf_q) lf_q <= pay;
				end else begin
					nb_q <= nb_q + 1'b1;
					ub_q <= ub_q + pay;
				end
				off_q <= off_walk;
			end
			default: begin
			end
		endcase
	end

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> state_q == ffha_pkg::ST_CLR && clr_q == '0)
		else $error("configuration write did not start a clearing pass");
	a_grant_in_arena: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffha_pkg::ST_A_CHK && fit) |-> off_q < arena_q)
		else $error("grant outside the arena");
	a_merge_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ffha_pkg::ST_F_W1 |-> merged >= sb_q && nx_q <= arena_q)
		else $error("merged block runs past the arena");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready && !cfg_we) |=> res_valid && $stable(res_q))
		else $error("pending result changed");

endmodule

// ===== sv/first_fit_heap_allocator_unit.sv =====
// First-fit heap allocator: stream ports, output register, header and back-link RAMs.
// Depends on ffha_pkg, ffha_ram and ffha_ctrl.
//
// A request word enters on the s_ channel: s_tuser carries the request kind (allocate,
// free, report) and s_tdata the size and release offset. Each request gives one result
// word on the m_ channel. One request is in progress at a time; the next is taken as
// soon as the sequencer has handed its result to the output register, even while that
// result still waits on m_tready, which holds it unchanged.
// Time per request follows the walk of the block chain: an allocate reads the blocks
// up to the fit (one more write if split) or all of them; a report reads all blocks;
// a free reads the block and its neighbours, or stops early on a rejected offset.
// After reset, and after every write of cfg_wdata (the arena size, clamped to 64..4096),
// a clearing pass wipes the header memory and lays down one free block; s_tready stays
// low during it. The user must write configuration only while the block is idle;
// the block itself does not enforce this.
`timescale 1ns / 1ps
module first_fit_heap_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // request_size[12:0], release_offset[24:13], zero fill
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // ok[0], granted_offset[12:1], used_blocks[22:13],
	                               // used_bytes[35:23], largest_free[48:36], zero fill
);

	ffha_pkg::item_t     item;
	ffha_pkg::result_t   res;
	ffha_pkg::main_req_t main_req;
	ffha_pkg::back_req_t back_req;
	ffha_pkg::hdr_t      main_rdata;
	logic [ffha_pkg::HDR_W-1:0]  main_rraw;
	logic [ffha_pkg::ADDR_W-1:0] back_rdata;
	logic idle, res_valid, res_ready, start;
	logic m_tvalid_q;
	ffha_pkg::result_t m_res_q;

	assign item.op   = s_tuser;
	assign item.req  = s_tdata[12:0];
	assign item.rel  = s_tdata[24:13];
	assign s_tready  = idle;
	assign start     = s_tvalid && idle;
	assign res_ready = !m_tvalid_q || m_tready;
	assign main_rdata = ffha_pkg::hdr_t'(main_rraw);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {7'd0, m_res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_res_q <= res;
		end
	end

	ffha_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.item       (item),
		.idle       (idle),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.main_req   (main_req),
		.main_rdata (main_rdata),
		.back_req   (back_req),
		.back_rdata (back_rdata)
	);

	ffha_ram #(.WIDTH(ffha_pkg::HDR_W), .DEPTH(ffha_pkg::ARENA_BYTES)) u_hdr_ram (
		.clk   (clk),
		.we    (main_req.we),
		.waddr (main_req.waddr),
		.wdata (main_req.wdata),
		.re    (main_req.re),
		.raddr (main_req.raddr),
		.rdata (main_rraw)
	);

	ffha_ram #(.WIDTH(ffha_pkg::ADDR_W), .DEPTH(ffha_pkg::ARENA_BYTES)) u_back_ram (
		.clk   (clk),
		.we    (back_req.we),
		.waddr (back_req.waddr),
		.wdata (back_req.wdata),
		.re    (back_req.re),
		.raddr (back_req.raddr),
		.rdata (back_rdata)
	);

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for first_fit_heap_allocator_unit: streams allocate, free and report
// requests, predicts every result word with a software copy of the block chain, and checks it.
// Depends on ffha_pkg and the RTL of the allocator.
`timescale 1ns / 1ps
module tb;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	class alloc_scoreboard;
		int unsigned blk_size [ffha_pkg::ARENA_BYTES];
		int unsigned back_link[ffha_pkg::ARENA_BYTES];
		bit          blk_start[ffha_pkg::ARENA_BYTES];
		bit          blk_free [ffha_pkg::ARENA_BYTES];
		int unsigned arena;
		ffha_pkg::result_t expected_q[$];
		int          errors;

		function void configure(int unsigned value);
			int unsigned v;
			v = value & 13'h1FFF;
			if (v > ffha_pkg::ARENA_BYTES) v = ffha_pkg::ARENA_BYTES;
			if (v < ffha_pkg::ARENA_MIN) v = ffha_pkg::ARENA_MIN;
			arena = v;
			for (int i = 0; i < ffha_pkg::ARENA_BYTES; i++) begin
				blk_size[i] = 0;
				back_link[i] = 0;
				blk_start[i] = 0;
				blk_free[i] = 0;
			end
			blk_size[0] = arena;
			blk_start[0] = 1;
			blk_free[0] = 1;
		endfunction

		function bit take_block(int unsigned want, output int unsigned granted);
			int unsigned off, pay, nxt, rest;
			off = 0;
			granted = 0;
			while (off < arena) begin
				pay = blk_size[off] - ffha_pkg::HEADER_BYTES;
				if (blk_free[off] && pay >= want) begin
					if (pay - want >= ffha_pkg::HEADER_BYTES) begin
						nxt = off + ffha_pkg::HEADER_BYTES + want;
						rest = blk_size[off] - ffha_pkg::HEADER_BYTES - want;
						blk_size[nxt] = rest;
						back_link[nxt] = off;
						blk_start[nxt] = 1;
						blk_free[nxt] = 1;
						blk_size[off] = ffha_pkg::HEADER_BYTES + want;
						if (nxt + rest < arena) back_link[nxt + rest] = nxt;
					end
					blk_free[off] = 0;
					granted = off + ffha_pkg::HEADER_BYTES;
					return 1;
				end
				off += blk_size[off];
			end
			return 0;
		endfunction

		function bit release_block(int unsigned rel);
			int unsigned b, nx, p, nn;
			bit prev_free, next_free;
			p = 0;
			prev_free = 0;
			next_free = 0;
			if (rel < ffha_pkg::HEADER_BYTES) return 0;
			b = rel - ffha_pkg::HEADER_BYTES;
			if (b >= arena || !blk_start[b] || blk_free[b]) return 0;
			nx = b + blk_size[b];
			if (b != 0) begin
				p = back_link[b];
				if (p < arena && blk_start[p] && blk_free[p]) prev_free = 1;
			end
			if (nx < arena && blk_free[nx]) next_free = 1;
			blk_free[b] = 1;
			if (prev_free && next_free) begin
				nn = nx + blk_size[nx];
				blk_size[p] += blk_size[b] + blk_size[nx];
				blk_start[b] = 0;
				blk_start[nx] = 0;
				if (nn < arena) back_link[nn] = p;
			end else if (prev_free) begin
				blk_size[p] += blk_size[b];
				blk_start[b] = 0;
				if (nx < arena) back_link[nx] = p;
			end else if (next_free) begin
				nn = nx + blk_size[nx];
				blk_size[b] += blk_size[nx];
				blk_start[nx] = 0;
				if (nn < arena) back_link[nn] = b;
			end
			return 1;
		endfunction

		function ffha_pkg::result_t note_request(logic [1:0] op, logic [12:0] req,
			logic [11:0] rel);
			ffha_pkg::result_t r;
			int unsigned off, pay, nb, ub, lf, g;
			r = '0;
			case (op)
				ffha_pkg::OP_ALLOC: begin
					if (take_block(req, g)) begin
						r.ok = 1;
						r.granted = g[11:0];
					end
				end
				ffha_pkg::OP_FREE: r.ok = release_block(rel);
				ffha_pkg::OP_REPORT: begin
					off = 0;
					nb = 0;
					ub = 0;
					lf = 0;
					while (off < arena) begin
						pay = blk_size[off] - ffha_pkg::HEADER_BYTES;
						if (blk_free[off]) begin
							if (pay > lf) lf = pay;
						end else begin
							nb++;
							ub += pay;
						end
						off += blk_size[off];
					end
					r.ok = 1;
					r.nb = (nb > 1023) ? 10'h3FF : nb[9:0];
					r.ub = (ub > 8191) ? 13'h1FFF : ub[12:0];
					r.lf = (lf > 8191) ? 13'h1FFF : lf[12:0];
				end
				default: r = '0;
			endcase
			expected_q.push_back(r);
			return r;
		endfunction

		function void check_result(ffha_pkg::result_t got);
			ffha_pkg::result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.ok !== e.ok) begin
				$display("%0t: ok expected %0d actual %0d", $time, e.ok, got.ok);
				errors++;
			end
			if (got.granted !== e.granted) begin
				$display("%0t: granted_offset expected %0d actual %0d", $time, e.granted,
					got.granted);
				errors++;
			end
			if (got.nb !== e.nb) begin
				$display("%0t: used_blocks expected %0d actual %0d", $time, e.nb, got.nb);
				errors++;
			end
			if (got.ub !== e.ub) begin
				$display("%0t: used_bytes expected %0d actual %0d", $time, e.ub, got.ub);
				errors++;
			end
			if (got.lf !== e.lf) begin
				$display("%0t: largest_free expected %0d actual %0d", $time, e.lf, got.lf);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [12:0] cfg_wdata = '0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [55:0] m_tdata;

	alloc_scoreboard sb = new();
	int unsigned live_offsets[$];
	bit          no_idle = 0;
	bit          hold_sink = 0;
	int          stall_count = 0;

	always #2 clk = ~clk;

	first_fit_heap_allocator_unit u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always @(negedge clk) begin
		if (hold_sink) begin
			m_tready = 0;
			repeat (300) @(negedge clk);
			hold_sink = 0;
		end else begin
			m_tready = no_idle || ($urandom_range(0, 99) >= 32);
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_result(ffha_pkg::result_t'(m_tdata[48:0]));
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_count <= 0;
		else stall_count <= stall_count + 1;
		if (stall_count > 20000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_request(logic [1:0] op, logic [12:0] req, logic [11:0] rel);
		ffha_pkg::result_t r;
		int idx;
		idx = -1;
		while (!no_idle && $urandom_range(0, 99) < 32) begin
			s_tvalid = 0;
			@(negedge clk);
		end
		s_tvalid = 1;
		s_tuser = op;
		s_tdata = {7'd0, rel, req};
		do @(posedge clk); while (!s_tready);
		r = sb.note_request(op, req, rel);
		if (op == ffha_pkg::OP_ALLOC && r.ok) live_offsets.push_back(32'(r.granted));
		if (op == ffha_pkg::OP_FREE && r.ok) begin
			foreach (live_offsets[i]) if (live_offsets[i] == rel) idx = i;
			if (idx >= 0) live_offsets.delete(idx);
		end
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic set_arena(logic [12:0] value);
		wait (sb.expected_q.size() == 0);
		repeat (40) @(negedge clk);
		cfg_we = 1;
		cfg_wdata = value;
		sb.configure(value);
		live_offsets.delete();
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic random_requests(int n);
		int unsigned pick, sz;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
					: $urandom_range(0, sb.arena / 8);
				send_request(ffha_pkg::OP_ALLOC, 13'(sz), 12'($urandom));
			end else if (pick < 80 && live_offsets.size() > 0) begin
				send_request(ffha_pkg::OP_FREE, 13'($urandom),
					12'(live_offsets[$urandom_range(0, live_offsets.size() - 1)]));
			end else if (pick < 88) begin
				send_request(ffha_pkg::OP_FREE, 13'($urandom), 12'($urandom));
			end else if (pick < 97) begin
				send_request(ffha_pkg::OP_REPORT, 13'($urandom), 12'($urandom));
			end else begin
				send_request(OP_UNUSED, 13'($urandom), 12'($urandom));
			end
		end
	endtask

	initial begin
		sb.configure(4096);
		repeat (8) @(negedge clk);
		arst_n = 1;

		send_request(ffha_pkg::OP_REPORT, 0, 0);
		send_request(ffha_pkg::OP_ALLOC, 13'h1FFF, 0);
		send_request(ffha_pkg::OP_ALLOC, 4096, 0);
		send_request(ffha_pkg::OP_FREE, 0, 12'hFFF);
		send_request(ffha_pkg::OP_FREE, 0, 0);
		send_request(ffha_pkg::OP_FREE, 0, 8);
		send_request(ffha_pkg::OP_ALLOC, 4080, 0);
		send_request(ffha_pkg::OP_ALLOC, 0, 0);
		send_request(ffha_pkg::OP_REPORT, 0, 0);
		send_request(ffha_pkg::OP_FREE, 0, 12);
		send_request(ffha_pkg::OP_FREE, 0, 8);
		send_request(ffha_pkg::OP_FREE, 0, 8);
		send_request(ffha_pkg::OP_ALLOC, 16, 0);
		send_request(ffha_pkg::OP_ALLOC, 16, 0);
		send_request(ffha_pkg::OP_ALLOC, 16, 0);
		send_request(ffha_pkg::OP_FREE, 0, 8);
		send_request(ffha_pkg::OP_FREE, 0, 56);
		send_request(ffha_pkg::OP_FREE, 0, 32);
		send_request(ffha_pkg::OP_REPORT, 0, 0);
		send_request(OP_UNUSED, 13'h1FFF, 12'hFFF);
		send_request(ffha_pkg::OP_ALLOC, 4088, 0);
		send_request(ffha_pkg::OP_REPORT, 0, 0);
		random_requests(60);

		no_idle = 1;
		random_requests(50);
		no_idle = 0;
		hold_sink = 1;
		random_requests(40);

		set_arena(64);
		send_request(ffha_pkg::OP_ALLOC, 57, 0);
		send_request(ffha_pkg::OP_ALLOC, 56, 0);
		send_request(ffha_pkg::OP_REPORT, 0, 0);
		random_requests(30);
		set_arena(13'h1FFF);
		random_requests(70);
		set_arena(0);
		random_requests(30);
		set_arena(1000);
		random_requests(60);
		set_arena(300);
		random_requests(40);
		set_arena(4096);
		random_requests(20);

		wait (sb.expected_q.size() == 0);
		repeat (100) @(posedge clk);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
